// ===== sv/mlfh_pkg.sv =====
// Shared types and constants for the FIFO mutex lock with handoff.
`default_nettype none
package mlfh_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TID_W   = 8;
    localparam int IN_DW   = 8;   // thread_id
    localparam int IN_UW   = 1;   // operation
    localparam int OUT_DW  = 24;  // woken_thread, owner_now, busy_now, zero fill
    localparam int OUT_UW  = 4;   // status, woken_valid

    typedef enum logic [0:0] {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_FREED     = 3'd4,
        ST_HANDOFF   = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

endpackage
`default_nettype wire

// ===== sv/mlfh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/mutex_lock_fifo_handoff.sv =====
// Hardware mutex with a FIFO wait queue of thread identifiers.
//
// Requests enter on the s_axis channel: s_axis_tuser carries the operation
// (acquire or release), s_axis_tdata the requesting thread. Every request
// produces exactly one result on m_axis: the status and woken flag in tuser,
// the woken thread, the owner after the request and the busy flag in tdata.
// A result is registered and shows in the cycle after its request's transfer.
// Throughput is one request per cycle when unstalled; the lock state
// and queue pointers update in the same cycle, and the head entry of the
// queue RAM is read ahead so a handoff never waits on the RAM read port.
// A result register separates the two sides: s_axis_tready stays high while
// the result register is empty or being drained, so a stall on m_axis_tready
// holds the pending result and blocks new requests only while it lasts.
// Reset frees the lock, clears the owner to zero and empties the queue; the
// queue RAM needs no clearing since only written entries are ever read.
`default_nettype none
module mutex_lock_fifo_handoff #(
    parameter int QUEUE_DEPTH = mlfh_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [mlfh_pkg::IN_DW-1:0]  s_axis_tdata,  // [7:0] thread_id
    input  wire logic [mlfh_pkg::IN_UW-1:0]  s_axis_tuser,  // [0] operation
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [7:0] woken_thread, [15:8] owner_now, [16] busy_now, [23:17] zero
    output logic      [mlfh_pkg::OUT_DW-1:0] m_axis_tdata,
    // [2:0] status, [3] woken_valid
    output logic      [mlfh_pkg::OUT_UW-1:0] m_axis_tuser
);

    import mlfh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    // lock and queue state
    logic             busy_reg,  busy_next;
    logic [TID_W-1:0] owner_reg, owner_next;
    logic [PTR_W-1:0] head_reg,  head_next;
    logic [PTR_W-1:0] tail_reg,  tail_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;

    // head read-ahead bypass
    logic             byp_valid_reg, byp_valid_next;
    logic [TID_W-1:0] byp_data_reg,  byp_data_next;

    // result register
    logic             out_valid_reg,  out_valid_next;
    status_t          status_reg,     status_next;
    logic             wv_reg,         wv_next;
    logic [TID_W-1:0] wt_reg,         wt_next;
    logic [TID_W-1:0] own_now_reg,    own_now_next;
    logic             busy_now_reg,   busy_now_next;

    logic             accept;
    logic             enq;
    op_t              op;
    logic [TID_W-1:0] tid;
    logic [TID_W-1:0] ram_rd;
    logic [TID_W-1:0] head_data;
    logic [PTR_W-1:0] head_eff;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser[0]);
    assign tid           = s_axis_tdata[TID_W-1:0];
    assign head_data     = byp_valid_reg ? byp_data_reg : ram_rd;

    always_comb
    begin
        busy_next     = busy_reg;
        owner_next    = owner_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        enq           = 1'b0;
        status_next   = ST_NOT_OWNER;
        wv_next       = 1'b0;
        wt_next       = '0;
        if (op == OP_ACQUIRE)
        begin
            if (busy_reg && owner_reg == tid)
            begin
                status_next = ST_ALREADY;
            end
            else if (!busy_reg)
            begin
                busy_next   = 1'b1;
                owner_next  = tid;
                status_next = ST_GRANTED;
            end
            else if (cnt_reg == CNT_FULL)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                enq         = 1'b1;
                tail_next   = ptr_inc(tail_reg);
                cnt_next    = CNT_W'(cnt_reg + 1'b1);
                status_next = ST_QUEUED;
            end
        end
        else
        begin
            if (!busy_reg || owner_reg != tid)
            begin
                status_next = ST_NOT_OWNER;
            end
            else if (cnt_reg != '0)
            begin
                head_next   = ptr_inc(head_reg);
                cnt_next    = CNT_W'(cnt_reg - 1'b1);
                owner_next  = head_data;
                wv_next     = 1'b1;
                wt_next     = head_data;
                status_next = ST_HANDOFF;
            end
            else
            begin
                busy_next   = 1'b0;
                owner_next  = '0;
                status_next = ST_FREED;
            end
        end
        own_now_next  = busy_next ? owner_next : '0;
        busy_now_next = busy_next;
    end

    // read ahead at the head the queue will have after this cycle
    assign head_eff       = accept ? head_next : head_reg;
    assign byp_valid_next = accept && enq && (tail_reg == head_eff);
    assign byp_data_next  = tid;
    assign out_valid_next = s_axis_tready ? s_axis_tvalid : out_valid_reg;

    mlfh_ram #(
        .WIDTH (TID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .clk     (clk),
        .wr_en   (accept && enq),
        .wr_addr (tail_reg),
        .wr_data (tid),
        .rd_addr (head_eff),
        .rd_data (ram_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            owner_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                busy_reg  <= busy_next;
                owner_reg <= owner_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        if (accept)
        begin
            status_reg   <= status_next;
            wv_reg       <= wv_next;
            wt_reg       <= wt_next;
            own_now_reg  <= own_now_next;
            busy_now_reg <= busy_now_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {wv_reg, status_reg};
    assign m_axis_tdata  = {{(OUT_DW - 2 * TID_W - 1){1'b0}}, busy_now_reg,
                            own_now_reg, wt_reg};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("wait count exceeds queue depth");

    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0)
        else $error("waiters present while lock is free");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with mismatched pointers");

    a_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("transfer produced no result");
`endif

endmodule
`default_nettype wire
